// ===== design/prpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared types and constants of the planar RLE plane decoder.
// ----------------------------------------------------------------------------
package prpd_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int COUNT_W    = 26;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [0:0] {
        REG_PLANE_WIDTH  = 1'b0,
        REG_PLANE_HEIGHT = 1'b1
    } t_reg_idx;

    localparam logic [3:0] RUN_NIB_LONG16 = 4'h1;
    localparam logic [3:0] RUN_NIB_LONG32 = 4'h2;
    localparam logic [5:0] LONG16_BASE    = 6'd16;
    localparam logic [5:0] LONG32_BASE    = 6'd32;

    localparam logic STATUS_PIXEL = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         pixel;
        logic               status;
        logic               last_of_burst;
        logic               plane_done;
        logic [COUNT_W-1:0] bytes_consumed;
    } t_out_item;

    // One issued result: error marker or one pixel to reconstruct
    typedef struct packed {
        logic               err;
        logic               use_above;
        logic [8:0]         run_value;
        logic               last;
        logic               done;
        logic [COUNT_W-1:0] bytes;
    } t_tok;

endpackage
`default_nettype wire

// ===== design/prpd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/prpd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_ctrl
// Byte parser and pixel sequencer: decodes control and raw bytes, tracks the
// plane position; issues one result per cycle while the pixel stage has room.
// ----------------------------------------------------------------------------
module prpd_ctrl
    import prpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_reg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_issue_ok,
    output logic                       o_issue,
    output t_tok                       o_tok,
    output logic [CW-1:0]              o_col
);

    localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14 = 14'(MAX_HEIGHT);

    typedef enum logic [3:0] {
        S_ACCEPT = 4'b0001,
        S_DRY    = 4'b0010,
        S_EMIT   = 4'b0100,
        S_ERR    = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        PH_CTRL    = 3'b001,
        PH_RAW     = 3'b010,
        PH_DISCARD = 3'b100
    } t_phase;

    function automatic logic [CW+RW+1:0] advance(
        input logic [CW-1:0] col,
        input logic [RW-1:0] row,
        input logic [13:0]   w,
        input logic [13:0]   h
    );
        logic [13:0]   col1;
        logic [13:0]   row1;
        logic [CW-1:0] col_n;
        logic [RW-1:0] row_n;
        logic          row_end;
        logic          done;
        col1    = 14'(col) + 14'd1;
        row1    = 14'(row) + 14'd1;
        col_n   = col1[CW-1:0];
        row_n   = row;
        row_end = 1'b0;
        done    = 1'b0;
        if (col1 >= w) begin
            col_n   = '0;
            row_end = 1'b1;
            row_n   = row1[RW-1:0];
            if (row1 >= h) begin
                row_n = '0;
                done  = 1'b1;
            end
        end
        return {done, row_end, row_n, col_n};
    endfunction

    logic [CFG_DATA_W-1:0] r_plane_width, r_plane_height;
    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [CW-1:0]         r_col, n_col, r_sim_col, n_sim_col;
    logic [RW-1:0]         r_row, n_row, r_sim_row, n_sim_row;
    logic [3:0]            r_raw_left, n_raw_left;
    logic [5:0]            r_run_pending, n_run_pending;
    logic [8:0]            r_run_value, n_run_value;
    logic [COUNT_W-1:0]    r_byte_count, n_byte_count;
    logic [5:0]            r_remain, n_remain, r_dry_cnt, n_dry_cnt;

    logic [13:0]        eff_w, eff_h, avail, need;
    logic [CW+RW+1:0]   m_adv, s_adv;
    logic [7:0]         b;
    logic               last, in_fire, ctrl_err, start_pix, do_fresh;
    logic [3:0]         raw_c;
    logic [5:0]         run_c, pix_n;
    logic [8:0]         delta, raw_val;
    logic [COUNT_W-1:0] count_inc;

    always_comb begin
        if (r_plane_width == '0) begin
            eff_w = 14'd1;
        end else if (14'(r_plane_width) > MAX_W14) begin
            eff_w = MAX_W14;
        end else begin
            eff_w = 14'(r_plane_width);
        end
        if (r_plane_height == '0) begin
            eff_h = 14'd1;
        end else if (14'(r_plane_height) > MAX_H14) begin
            eff_h = MAX_H14;
        end else begin
            eff_h = 14'(r_plane_height);
        end
    end

    assign m_adv = advance(r_col, r_row, eff_w, eff_h);
    assign s_adv = advance(r_sim_col, r_sim_row, eff_w, eff_h);

    assign b       = i_in_item.data_byte;
    assign last    = i_in_item.last_byte;
    assign in_fire = i_in_valid && (r_state == S_ACCEPT);

    assign o_in_stall = (r_state != S_ACCEPT);
    assign o_col      = r_col;

    always_comb begin
        case (b[3:0])
            RUN_NIB_LONG16: begin
                raw_c = 4'd0;
                run_c = {2'b00, b[7:4]} + LONG16_BASE;
            end
            RUN_NIB_LONG32: begin
                raw_c = 4'd0;
                run_c = {2'b00, b[7:4]} + LONG32_BASE;
            end
            default: begin
                raw_c = b[7:4];
                run_c = {2'b00, b[3:0]};
            end
        endcase
        avail    = (14'(r_col) < eff_w) ? (eff_w - 14'(r_col)) : 14'd0;
        need     = 14'(raw_c) + 14'(run_c);
        ctrl_err = (b == 8'd0) || (need > avail) || ((raw_c != 4'd0) && last);
        delta    = b[0] ? ~{2'b00, b[7:1]} : {2'b00, b[7:1]};
        raw_val  = (r_row != '0) ? delta : {1'b0, b};
        count_inc = (r_byte_count != COUNT_MAX) ? (r_byte_count + 1'b1) : r_byte_count;
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_col         = r_col;
        n_row         = r_row;
        n_sim_col     = r_sim_col;
        n_sim_row     = r_sim_row;
        n_raw_left    = r_raw_left;
        n_run_pending = r_run_pending;
        n_run_value   = r_run_value;
        n_byte_count  = r_byte_count;
        n_remain      = r_remain;
        n_dry_cnt     = r_dry_cnt;
        start_pix     = 1'b0;
        do_fresh      = 1'b0;
        pix_n         = 6'd0;
        o_issue       = 1'b0;
        o_tok         = '0;

        case (r_state)
            S_ACCEPT: begin
                if (in_fire) begin
                    case (r_phase)
                        PH_DISCARD: begin
                            do_fresh = last;
                        end
                        PH_RAW: begin
                            n_byte_count = count_inc;
                            n_run_value  = raw_val;
                            n_raw_left   = r_raw_left - 4'd1;
                            pix_n        = 6'd1;
                            if (r_raw_left == 4'd1) begin
                                pix_n         = 6'd1 + r_run_pending;
                                n_run_pending = 6'd0;
                                n_phase       = PH_CTRL;
                            end
                            start_pix = 1'b1;
                        end
                        default: begin
                            n_byte_count = count_inc;
                            if (ctrl_err) begin
                                n_state = S_ERR;
                                if (last) begin
                                    do_fresh = 1'b1;
                                end else begin
                                    n_phase = PH_DISCARD;
                                end
                            end else if (raw_c != 4'd0) begin
                                n_raw_left    = raw_c;
                                n_run_pending = run_c;
                                n_phase       = PH_RAW;
                            end else begin
                                pix_n     = run_c;
                                start_pix = 1'b1;
                            end
                        end
                    endcase
                    if (start_pix) begin
                        n_remain  = pix_n;
                        n_dry_cnt = pix_n;
                        n_sim_col = r_col;
                        n_sim_row = r_row;
                        n_state   = last ? S_DRY : S_EMIT;
                    end
                end
            end
            S_DRY: begin
                n_sim_col = s_adv[CW-1:0];
                n_sim_row = s_adv[CW+RW-1:CW];
                n_dry_cnt = r_dry_cnt - 6'd1;
                if (r_dry_cnt == 6'd1) begin
                    if (s_adv[CW+RW+1]) begin
                        n_state = S_EMIT;
                    end else begin
                        do_fresh = 1'b1;
                        n_state  = S_ERR;
                    end
                end
            end
            S_EMIT: begin
                if (i_issue_ok) begin
                    o_issue         = 1'b1;
                    o_tok.use_above = (r_row != '0);
                    o_tok.run_value = r_run_value;
                    o_tok.last      = (r_remain == 6'd1);
                    o_tok.done      = m_adv[CW+RW+1];
                    o_tok.bytes     = m_adv[CW+RW+1] ? r_byte_count : '0;
                    n_col           = m_adv[CW-1:0];
                    n_row           = m_adv[CW+RW-1:CW];
                    if (m_adv[CW+RW]) begin
                        n_run_value = 9'd0;
                    end
                    if (m_adv[CW+RW+1]) begin
                        n_byte_count = '0;
                    end
                    n_remain = r_remain - 6'd1;
                    if (r_remain == 6'd1) begin
                        n_state = S_ACCEPT;
                    end
                end
            end
            S_ERR: begin
                if (i_issue_ok) begin
                    o_issue    = 1'b1;
                    o_tok.err  = 1'b1;
                    o_tok.last = 1'b1;
                    n_state    = S_ACCEPT;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase

        if (do_fresh) begin
            n_col         = '0;
            n_row         = '0;
            n_raw_left    = 4'd0;
            n_run_pending = 6'd0;
            n_run_value   = 9'd0;
            n_phase       = PH_CTRL;
            n_byte_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_width  <= CFG_DATA_W'(64);
            r_plane_height <= CFG_DATA_W'(64);
            r_state        <= S_ACCEPT;
            r_phase        <= PH_CTRL;
            r_col          <= '0;
            r_row          <= '0;
            r_raw_left     <= 4'd0;
            r_run_pending  <= 6'd0;
            r_run_value    <= 9'd0;
            r_byte_count   <= '0;
            r_remain       <= 6'd0;
            r_dry_cnt      <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PLANE_WIDTH:  r_plane_width  <= i_cfg_data;
                    REG_PLANE_HEIGHT: r_plane_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_col         <= n_col;
            r_row         <= n_row;
            r_raw_left    <= n_raw_left;
            r_run_pending <= n_run_pending;
            r_run_value   <= n_run_value;
            r_byte_count  <= n_byte_count;
            r_remain      <= n_remain;
            r_dry_cnt     <= n_dry_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sim_col <= n_sim_col;
        r_sim_row <= n_sim_row;
    end

endmodule
`default_nettype wire

// ===== design/prpd_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_pixel
// Pixel reconstruction stage: adds the run value to the pixel above (from row
// 1 on), clamps, writes the line store, queues in a two-entry output queue.
// ----------------------------------------------------------------------------
module prpd_pixel
    import prpd_pkg::*;
#(
    parameter int AW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_issue,
    input  wire t_tok          i_tok,
    input  wire logic [AW-1:0] i_col,
    input  wire logic [7:0]    i_rdata,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [7:0]         o_wdata,
    output logic               o_issue_ok,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output t_out_item          o_out_item
);

    logic          r_b_valid;
    t_tok          r_b_tok;
    logic [AW-1:0] r_b_col;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [7:0]    r_fwd_data;
    t_out_item     r_q [2];
    logic [1:0]    r_cnt;

    logic [7:0]  above, pix;
    logic [9:0]  sum;
    logic [2:0]  occ;
    logic [1:0]  wr_pos;
    logic        pop;
    t_out_item   res;

    always_comb begin
        above = (r_fwd_valid && (r_fwd_addr == r_b_col)) ? r_fwd_data : i_rdata;
        sum   = {r_b_tok.run_value[8], r_b_tok.run_value}
              + (r_b_tok.use_above ? {2'b00, above} : 10'd0);
        pix   = sum[9] ? 8'd0 : (sum[8] ? 8'hff : sum[7:0]);
        if (r_b_tok.err) begin
            res                = '0;
            res.status         = STATUS_ERROR;
            res.last_of_burst  = 1'b1;
        end else begin
            res.pixel          = pix;
            res.status         = STATUS_PIXEL;
            res.last_of_burst  = r_b_tok.last;
            res.plane_done     = r_b_tok.done;
            res.bytes_consumed = r_b_tok.bytes;
        end
    end

    assign o_we    = r_b_valid && !r_b_tok.err;
    assign o_waddr = r_b_col;
    assign o_wdata = pix;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q[0];
    assign pop         = o_out_valid && !i_out_stall;
    assign occ         = {1'b0, r_cnt} + {2'b00, r_b_valid};
    assign o_issue_ok  = (occ < 3'd2) || ((occ == 3'd2) && pop);
    assign wr_pos      = r_cnt - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            r_b_valid   <= i_issue;
            r_fwd_valid <= o_we;
            r_cnt       <= r_cnt + {1'b0, r_b_valid} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_tok    <= i_tok;
        r_b_col    <= i_col;
        r_fwd_addr <= r_b_col;
        r_fwd_data <= pix;
        if (r_b_valid && (wr_pos[0] == 1'b0)) begin
            r_q[0] <= res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (r_b_valid && (wr_pos[0] == 1'b1)) begin
            r_q[1] <= res;
        end
    end

endmodule
`default_nettype wire

// ===== design/planar_rle_plane_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// planar_rle_plane_decoder
// Streaming decoder of one RLE-compressed color plane, one byte per item.
// ----------------------------------------------------------------------------
// Each input item is one compressed byte; results come out in raster order,
// one pixel per item, or a single error item. A byte that yields pixels holds
// the input while they are issued one by one as the pixel stage has room,
// each by a read-modify-write of the line store (one read and one write port,
// registered read data, write-to-read forwarding). A byte marked last that
// yields pixels first pre-scans the plane position, one step per pixel, to
// decide whether it completes the plane. Results pass through a two-entry
// output queue, so output stalls do not disturb the line store pipeline.
// The line store has no reset and no clearing pass; plane size changes take
// effect at once.
module planar_rle_plane_decoder
    import prpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_reg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          w_issue, w_issue_ok, w_we;
    t_tok          w_tok;
    logic [CW-1:0] w_col, w_waddr;
    logic [7:0]    w_rdata, w_wdata;

    prpd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_issue_ok  (w_issue_ok),
        .o_issue     (w_issue),
        .o_tok       (w_tok),
        .o_col       (w_col)
    );

    prpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    prpd_pixel #(
        .AW (CW)
    ) u_pixel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_tok       (w_tok),
        .i_col       (w_col),
        .i_rdata     (w_rdata),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_issue_ok  (w_issue_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_no_issue_while_accepting: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_issue
    ) else $error("result issued while input is open");

    a_error_item_shape: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == STATUS_ERROR)) |->
            (o_out_item.last_of_burst && !o_out_item.plane_done
             && (o_out_item.pixel == 8'd0))
    ) else $error("malformed error item");

    a_count_only_on_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.plane_done) |-> (o_out_item.bytes_consumed == '0)
    ) else $error("byte count shown outside plane end");

endmodule
`default_nettype wire
